>>> rtl/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
// No dependencies.
package lsc_pkg;
	localparam int REG_WIDTH = 24;
	localparam int CFG_IDX_WIDTH = 2;
	localparam int MAX_PASSES = 4;
	localparam logic [3:0] OC_LEFT = 4'b0001;
	localparam logic [3:0] OC_RIGHT = 4'b0010;
	localparam logic [3:0] OC_BOTTOM = 4'b0100;
	localparam logic [3:0] OC_TOP = 4'b1000;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_LEFT = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_RIGHT = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_BOTTOM = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TOP = 2'd3;
	typedef struct packed {
		logic signed [REG_WIDTH-1:0] left;
		logic signed [REG_WIDTH-1:0] right;
		logic signed [REG_WIDTH-1:0] bottom;
		logic signed [REG_WIDTH-1:0] top;
	} window_t;
endpackage

>>> rtl/lsc_front.sv
// Front end: accepts segments and holds them in a two-entry queue.
// Depends on lsc_pkg.
module lsc_front import lsc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output logic q_valid,
	input  logic q_pop,
	output logic [4*COORD_WIDTH-1:0] q_word
);
	logic [4*COORD_WIDTH-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	assign busy = cnt_q[1];
	assign push = start && !busy;
	assign q_valid = cnt_q != 2'd0;
	assign q_word = mem_q[rp_q];
	// store pushed words
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= {start_x, start_y, end_x, end_y};
	end
	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

>>> rtl/lsc_div.sv
// Restoring divider, one quotient bit per cycle, 128-bit dividend.
// Saturates quotient to 2**62. No dependencies.
module lsc_div #(
	parameter int DW = 128,
	parameter int QW = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [DW-1:0] dividend,
	input  logic [QW-1:0] divisor,
	output logic done,
	output logic [QW-1:0] quot
);
	localparam int CW = $clog2(DW+1);
	logic [DW-1:0] num_q;
	logic [QW:0] rem_q;
	logic [QW-1:0] q_q, den_q;
	logic over_q, run_q;
	logic [CW-1:0] cnt_q;
	logic [QW:0] rs;
	assign rs = {rem_q[QW-1:0], num_q[DW-1]};
	assign quot = (over_q || q_q > (QW'(1) << 62)) ? (QW'(1) << 62) : q_q;
	// iterate shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0; done <= 1'b0; cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1; cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend; den_q <= divisor; rem_q <= '0; q_q <= '0; over_q <= 1'b0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (q_q[QW-1:62] != '0) over_q <= 1'b1;
			if (rs >= {1'b0, den_q}) begin
				rem_q <= rs - {1'b0, den_q};
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rs;
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/lsc_back.sv
// Back end: Cohen-Sutherland clip sequencer, multiplier split over S_MLO
// and S_MHI, and serial divider. Depends on lsc_pkg and lsc_div.
module lsc_back import lsc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  window_t win,
	input  logic q_valid,
	output logic q_pop,
	input  logic [4*COORD_WIDTH-1:0] q_word,
	output logic done,
	output logic signed [COORD_WIDTH-1:0] out_start_x,
	output logic signed [COORD_WIDTH-1:0] out_start_y,
	output logic signed [COORD_WIDTH-1:0] out_end_x,
	output logic signed [COORD_WIDTH-1:0] out_end_y,
	output logic rejected
);
	localparam int W = 64;
	localparam logic signed [W-1:0] CHI = W'((65'sd1 <<< (COORD_WIDTH-1)) - 1);
	localparam logic signed [W-1:0] CLO = -CHI - 1;
	typedef enum logic [3:0] {
		S_IDLE, S_TEST, S_SETUP, S_MLO, S_MHI, S_GO, S_DIV, S_FIN, S_OUT
	} state_t;
	state_t state_q;
	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q, a1_q, edge_q;
	logic [3:0] c1_q, c2_q;
	logic [2:0] pass_q;
	logic usex_q, neg_q, zero_q;
	logic [W-1:0] m1_q, m2_q, md_q;
	logic [127:0] prod_q;
	logic [95:0] plo_q;
	logic div_go, div_done;
	logic [W-1:0] quot;
	logic [3:0] c2n, c1n;
	logic [3:0] c1s, c2s;
	logic signed [W-1:0] ax1, ay1, ax2, ay2, edg, n1, n2, d, res;
	logic cx;

	function automatic logic [3:0] oc(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y, input window_t w);
		logic [3:0] c;
		c = 4'b0;
		if (x < W'(w.left)) c = c | OC_LEFT;
		else if (x > W'(w.right)) c = c | OC_RIGHT;
		if (y < W'(w.bottom)) c = c | OC_BOTTOM;
		else if (y > W'(w.top)) c = c | OC_TOP;
		return c;
	endfunction
	function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
		if (v > (W+1)'(CHI)) return CHI;
		if (v < (W+1)'(CLO)) return CLO;
		return v[W-1:0];
	endfunction
	function automatic logic [W-1:0] mg(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : v;
	endfunction

	// swap so the outside endpoint comes first, then pick the edge
	always_comb begin
		if (c1_q == 4'b0) begin
			ax1 = x2_q; ay1 = y2_q; ax2 = x1_q; ay2 = y1_q; c1s = c2_q; c2s = c1_q;
		end else begin
			ax1 = x1_q; ay1 = y1_q; ax2 = x2_q; ay2 = y2_q; c1s = c1_q; c2s = c2_q;
		end
		cx = 1'b1;
		if ((c1s & OC_LEFT) != 4'b0) edg = W'(win.left);
		else if ((c1s & OC_RIGHT) != 4'b0) edg = W'(win.right);
		else begin
			cx = 1'b0;
			if ((c1s & OC_BOTTOM) != 4'b0) edg = W'(win.bottom);
			else edg = W'(win.top);
		end
		if (cx) begin
			n1 = ay2 - ay1; n2 = edg - ax1; d = ax2 - ax1;
		end else begin
			n1 = ax2 - ax1; n2 = edg - ay1; d = ay2 - ay1;
		end
	end
	assign c1n = oc(x1_q, y1_q, win);
	assign c2n = oc(x2_q, y2_q, win);
	assign res = sat(neg_q ? {a1_q[W-1], a1_q} - {1'b0, quot}
		: {a1_q[W-1], a1_q} + {1'b0, quot});
	assign div_go = (state_q == S_GO);
	assign q_pop = (state_q == S_IDLE) && q_valid;

	lsc_div #(.DW(128), .QW(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(prod_q),
		.divisor(md_q), .done(div_done), .quot(quot)
	);

	// sequence clip passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid) state_q <= S_TEST;
				S_TEST: begin
					if ((c1n | c2n) == 4'b0 || (c1n & c2n) != 4'b0
						|| pass_q == 3'(MAX_PASSES)) begin
						state_q <= S_OUT; done <= 1'b1;
					end else state_q <= S_SETUP;
				end
				S_SETUP: state_q <= S_MLO;
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= zero_q ? S_FIN : S_GO;
				S_GO: state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= S_FIN;
				S_FIN: state_q <= S_TEST;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (q_valid) begin
				x1_q <= W'($signed(q_word[4*COORD_WIDTH-1:3*COORD_WIDTH]));
				y1_q <= W'($signed(q_word[3*COORD_WIDTH-1:2*COORD_WIDTH]));
				x2_q <= W'($signed(q_word[2*COORD_WIDTH-1:COORD_WIDTH]));
				y2_q <= W'($signed(q_word[COORD_WIDTH-1:0]));
				pass_q <= '0;
				c1_q <= 4'b0; c2_q <= 4'b0;
			end
			S_TEST: begin
				c1_q <= c1n; c2_q <= c2n;
			end
			S_FIN: begin
				if (usex_q) y1_q <= zero_q ? sat({a1_q[W-1], a1_q}) : res;
				else x1_q <= zero_q ? sat({a1_q[W-1], a1_q}) : res;
			end
			S_SETUP: begin
				x1_q <= ax1; y1_q <= ay1; x2_q <= ax2; y2_q <= ay2;
				c1_q <= c1s; c2_q <= c2s; usex_q <= cx;
				edge_q <= edg; a1_q <= cx ? ay1 : ax1;
				neg_q <= (n1[W-1] ^ n2[W-1]) ^ d[W-1];
				zero_q <= (d == '0) || (n1 == '0) || (n2 == '0);
				m1_q <= mg(n1); m2_q <= mg(n2); md_q <= mg(d);
				pass_q <= pass_q + 3'd1;
			end
			S_MLO: begin
				prod_q <= {64'b0, 64'(m1_q[31:0]) * 64'(m2_q[31:0])};
				plo_q <= {32'b0, 64'(m1_q[31:0]) * 64'(m2_q[63:32])};
			end
			S_MHI: prod_q <= prod_q + {plo_q, 32'b0}
				+ {32'b0, 64'(m1_q[63:32]) * 64'(m2_q[31:0]), 32'b0}
				+ {64'(m1_q[63:32]) * 64'(m2_q[63:32]), 64'b0};
			default: ;
		endcase
		// the edge coordinate replaces the clipped one after each pass
		if (state_q == S_FIN) begin
			if (usex_q) x1_q <= sat({edge_q[W-1], edge_q});
			else y1_q <= sat({edge_q[W-1], edge_q});
		end
	end
	assign out_start_x = x1_q[COORD_WIDTH-1:0];
	assign out_start_y = y1_q[COORD_WIDTH-1:0];
	assign out_end_x = x2_q[COORD_WIDTH-1:0];
	assign out_end_y = y2_q[COORD_WIDTH-1:0];
	// hold reject flag from the final test
	always_ff @(posedge clk) begin
		if (state_q == S_TEST) rejected <= (c1n | c2n) != 4'b0;
	end
endmodule

>>> rtl/line_segment_clipper_core.sv
// Line segment clipper top level: window registers, front queue, back clipper.
// Depends on lsc_pkg, lsc_front, lsc_back.
//
// Usage: drive start_x..end_y and pulse start while busy is low; the segment
// enters a two-entry queue. The back end pops it, computes outcodes, and runs
// up to four clip passes. Each pass runs S_SETUP, S_MLO and S_MHI, then the
// 128-step serial divider (one quotient bit per cycle) via S_GO and S_DIV,
// then S_FIN; a pass whose divisor or numerator is zero skips the divider.
// The back end takes the next segment the cycle after the result.
// The result appears on out_* and rejected for one cycle with done high; the
// receiver cannot stall. Window registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data while no segment is in flight;
// cfg_ready is always high, indexes of 4 or more are ignored. Reset sets the
// window to -2048.0 .. 2047.0 on both axes and empties the queue.
module line_segment_clipper_core import lsc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output logic done,
	output logic signed [COORD_WIDTH-1:0] out_start_x,
	output logic signed [COORD_WIDTH-1:0] out_start_y,
	output logic signed [COORD_WIDTH-1:0] out_end_x,
	output logic signed [COORD_WIDTH-1:0] out_end_y,
	output logic rejected,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [REG_WIDTH-1:0] cfg_data
);
	localparam logic signed [REG_WIDTH-1:0] WLO = REG_WIDTH'(-(64'sd2048 <<< FRAC_BITS));
	localparam logic signed [REG_WIDTH-1:0] WHI = REG_WIDTH'(64'sd2047 <<< FRAC_BITS);
	window_t win_q;
	logic q_valid, q_pop;
	logic [4*COORD_WIDTH-1:0] q_word;
	assign cfg_ready = 1'b1;
	// write window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= {WLO, WHI, WLO, WHI};
		end else if (cfg_valid && cfg_index[7:CFG_IDX_WIDTH] == '0) begin
			case (cfg_index[CFG_IDX_WIDTH-1:0])
				REG_LEFT: win_q.left <= cfg_data;
				REG_RIGHT: win_q.right <= cfg_data;
				REG_BOTTOM: win_q.bottom <= cfg_data;
				REG_TOP: win_q.top <= cfg_data;
				default: ;
			endcase
		end
	end
	lsc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
	);
	lsc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .win(win_q), .q_valid(q_valid), .q_pop(q_pop),
		.q_word(q_word), .done(done), .out_start_x(out_start_x),
		.out_start_y(out_start_y), .out_end_x(out_end_x), .out_end_y(out_end_y),
		.rejected(rejected)
	);
endmodule

>>> rtl/lsc_checker.sv
// Port-level checks for the clipper core, bound to the top level.
// Depends on line_segment_clipper_core.
module lsc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);
	a_no_back_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("cfg_ready dropped");
	a_busy_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without accepted word");
endmodule
bind line_segment_clipper_core lsc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .cfg_ready(cfg_ready)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_segment_clipper_core: drives segments and
// window writes, predicts every clipped word in place. Depends on lsc_pkg.
module testbench;
	import lsc_pkg::*;

	localparam int CW = 32;

	typedef struct {
		logic signed [CW-1:0] sx, sy, ex, ey;
		logic rej;
	} clip_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic done;
	logic signed [CW-1:0] out_start_x, out_start_y, out_end_x, out_end_y;
	logic rejected;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [REG_WIDTH-1:0] cfg_data = '0;

	longint win_left, win_right, win_bottom, win_top;
	clip_word_t clip_expected[$];
	int errors = 0;
	int n_words = 0;
	int n_rejected = 0;
	int send_idle_pct = 0;

	always #4 clk = ~clk;

	line_segment_clipper_core i_dut (.*);

	// Saturate to the signed coordinate range
	function automatic longint sat_coord(longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [3:0] region_code(longint x, longint y);
		logic [3:0] c;
		c = '0;
		if (x < win_left) c |= OC_LEFT;
		else if (x > win_right) c |= OC_RIGHT;
		if (y < win_bottom) c |= OC_BOTTOM;
		else if (y > win_top) c |= OC_TOP;
		return c;
	endfunction

	// Move along the segment to the edge: exact product, truncating quotient
	function automatic longint edge_cross(longint a1, longint a2, longint b1, longint b2,
			longint edge_pos);
		logic signed [127:0] num, den, quo;
		logic [127:0] mq, cap;
		longint q;
		if (b2 == b1 || a2 == a1 || edge_pos == b1) return sat_coord(a1);
		num = 128'(a2 - a1) * 128'(edge_pos - b1);
		den = 128'(b2 - b1);
		quo = num / den;
		mq = quo < 0 ? -quo : quo;
		cap = 128'(1) << 62;
		if (mq > cap) mq = cap;
		q = longint'(mq[63:0]);
		return sat_coord(quo < 0 ? a1 - q : a1 + q);
	endfunction

	function automatic clip_word_t clip_segment(longint x1, longint y1, longint x2,
			longint y2);
		clip_word_t w;
		logic [3:0] c1, c2, ct;
		longint t;
		int pass;
		c1 = region_code(x1, y1);
		c2 = region_code(x2, y2);
		w.rej = 1'b0;
		pass = 0;
		while ((c1 | c2) != 0) begin
			if ((c1 & c2) != 0 || pass >= MAX_PASSES) begin
				w.rej = 1'b1;
				break;
			end
			pass++;
			if (c1 == 0) begin
				ct = c1; c1 = c2; c2 = ct;
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
			end
			if (c1 & OC_LEFT) begin
				y1 = edge_cross(y1, y2, x1, x2, win_left);
				x1 = sat_coord(win_left);
			end else if (c1 & OC_RIGHT) begin
				y1 = edge_cross(y1, y2, x1, x2, win_right);
				x1 = sat_coord(win_right);
			end else if (c1 & OC_BOTTOM) begin
				x1 = edge_cross(x1, x2, y1, y2, win_bottom);
				y1 = sat_coord(win_bottom);
			end else begin
				x1 = edge_cross(x1, x2, y1, y2, win_top);
				y1 = sat_coord(win_top);
			end
			c1 = region_code(x1, y1);
		end
		w.sx = x1[CW-1:0]; w.sy = y1[CW-1:0];
		w.ex = x2[CW-1:0]; w.ey = y2[CW-1:0];
		return w;
	endfunction

	// Send one segment; predict its word at acceptance. Start stays high
	// until the next idle cycle or drain drops it.
	task automatic send_segment(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
			logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
		@(posedge clk);
		while (busy) @(posedge clk);
		clip_expected.push_back(clip_segment(sx, sy, ex, ey));
	endtask

	// Drop start, drain, then hold off a while longer
	task automatic wait_idle();
		start <= 1'b0;
		while (clip_expected.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	// Write one register; cfg_valid stays high until the caller drops it
	task automatic write_window(logic [7:0] idx, logic [REG_WIDTH-1:0] val);
		longint v;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		v = longint'(signed'(val));
		case (idx)
			8'(REG_LEFT): win_left = v;
			8'(REG_RIGHT): win_right = v;
			8'(REG_BOTTOM): win_bottom = v;
			8'(REG_TOP): win_top = v;
			default: ;
		endcase
	endtask

	task automatic set_window(int l, int r, int b, int t);
		wait_idle();
		write_window(8'(REG_LEFT), l[REG_WIDTH-1:0]);
		write_window(8'(REG_RIGHT), r[REG_WIDTH-1:0]);
		write_window(8'(REG_BOTTOM), b[REG_WIDTH-1:0]);
		write_window(8'(REG_TOP), t[REG_WIDTH-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// Check each word against the oldest prediction
	always @(posedge clk) begin
		clip_word_t e;
		if (arst_n && done) begin
			n_words++;
			if (rejected) n_rejected++;
			if (clip_expected.size() == 0) begin
				$display("%0t: unexpected word %h %h %h %h %b", $realtime, out_start_x,
					out_start_y, out_end_x, out_end_y, rejected);
				errors++;
			end else begin
				e = clip_expected.pop_front();
				if (out_start_x !== e.sx || out_start_y !== e.sy || out_end_x !== e.ex
						|| out_end_y !== e.ey || rejected !== e.rej) begin
					$display("%0t: expected %h %h %h %h %b actual %h %h %h %h %b", $realtime,
						e.sx, e.sy, e.ex, e.ey, e.rej, out_start_x, out_start_y,
						out_end_x, out_end_y, rejected);
					errors++;
				end
			end
		end
	end

	function automatic logic signed [CW-1:0] rand_coord(int span);
		case ($urandom_range(5))
			0: return $urandom;
			1: return -(1 <<< 31) + $urandom_range(3);
			2: return 32'h7fffffff - $urandom_range(3);
			default: return $signed($urandom_range(2 * span)) - span;
		endcase
	endfunction

	task automatic test_directed();
		send_segment(0, 0, 256, 256);
		send_segment(-600000, 0, 600000, 0);
		send_segment(0, -600000, 0, 600000);
		send_segment(-600000, -600000, 600000, 600000);
		send_segment(-600000, 0, -700000, 10);
		send_segment(700000, 5, 700000, 900);
		send_segment(0, 700000, 10, 800000);
		send_segment(3, -700000, 9, -800000);
		send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
		send_segment(-600000, 500000, 0, 900000);
		send_segment(100, 100, 100, 100);
		send_segment(-524288, 524032, 524032, -524288);
		send_segment(32'h80000000, 0, 32'h7fffffff, 1);
		// Inverted windows exercise the pass limit and odd divisors
		set_window(1000, -1000, 1000, -1000);
		send_segment(0, 0, 5, 5);
		send_segment(-5000, 3, 5000, -7);
		send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		set_window(-(1 << 23), (1 << 23) - 1, -(1 << 23), (1 << 23) - 1);
		send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_segment(0, 0, 1, 1);
		// An out-of-range index must leave the window alone
		wait_idle();
		write_window(8'd4, 24'h123456);
		write_window(8'hff, 24'h800000);
		cfg_valid <= 1'b0;
		send_segment(32'h80000000, 5, 32'h7fffffff, 9);
	endtask

	task automatic test_random(int count, int span);
		repeat (count) begin
			send_segment(rand_coord(span), rand_coord(span), rand_coord(span),
				rand_coord(span));
		end
	endtask

	task automatic test_windows();
		int l, r, b, t;
		repeat (4) begin
			l = $signed($urandom_range(400000)) - 300000;
			r = l + $urandom_range(400000);
			b = $signed($urandom_range(400000)) - 300000;
			t = b + $urandom_range(400000);
			if ($urandom_range(3) == 0) t = b - 7;
			set_window(l, r, b, t);
			test_random(200, 1200000);
		end
		set_window(-524288, 524032, -524288, 524032);
	endtask

	initial begin
		win_left = -524288; win_right = 524032; win_bottom = -524288; win_top = 524032;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 0; test_random(400, 1000000);
		send_idle_pct = 70; test_random(400, 1000000);
		// Pause until every word is back before resuming
		wait_idle();
		send_idle_pct = 27; test_random(400, 1000000);
		send_idle_pct = 0; test_windows();
		wait_idle();
		$display("Covered %0d words (%0d rejected): extremes, inverted and random windows,",
			n_words, n_rejected);
		$display("bad register indexes and idle phases on the sender side.");
		if (errors == 0 && clip_expected.size() == 0)
			$display("line_segment_clipper_core regression: pass");
		else
			$display("line_segment_clipper_core regression: fail");
		$finish;
	end

	initial begin
		#50ms;
		$display("line_segment_clipper_core regression: fail");
		$finish;
	end
endmodule
